// File: design/mea_pkg.sv
`timescale 1ns / 1ps

package mea_pkg;

    localparam int LANES     = 8;
    localparam int EXP_BITS  = 8;
    localparam int SLOT_BITS = 8;
    localparam int DATA_BITS = LANES * SLOT_BITS;
    localparam int DEG_BITS  = 11;
    localparam int CMD_BITS  = 3;
    localparam int MODE_BITS = 2;
    localparam int VC_BITS   = 4;
    localparam int CFG_BITS  = 4;
    localparam int IN_BITS   = ((CMD_BITS + 2 * DATA_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = ((DATA_BITS + 5 + DEG_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MIN = 3'd2,
        CMD_MAX = 3'd3,
        CMD_OR  = 3'd4,
        CMD_NEG = 3'd5
    } cmd_t;

    localparam logic [MODE_BITS-1:0] ORD_LEX        = 2'd0;
    localparam logic [MODE_BITS-1:0] ORD_DEG_LEX    = 2'd1;
    localparam logic [MODE_BITS-1:0] ORD_DEG_INVLEX = 2'd2;

    localparam logic CFG_ORDER_MODE = 1'b0;
    localparam logic CFG_VAR_COUNT  = 1'b1;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic                 ovf;
        logic                 ge;
        logic                 le;
        logic                 ne;
        logic                 gt;
        logic [EXP_BITS-1:0]  x;
        logic [EXP_BITS-1:0]  y;
    } lane_t;

    typedef struct packed {
        logic [DEG_BITS-1:0]  degree_a;
        logic                 order_greater;
        logic                 vectors_equal;
        logic                 a_le_b;
        logic                 a_ge_b;
        logic                 overflow;
        logic [DATA_BITS-1:0] result_exps;
    } result_t;

endpackage

// File: design/mea_lane.sv
`timescale 1ns / 1ps

module mea_lane (
    input  logic [mea_pkg::CMD_BITS-1:0]  cmd,
    input  logic [mea_pkg::SLOT_BITS-1:0] a_slot,
    input  logic [mea_pkg::SLOT_BITS-1:0] b_slot,
    input  logic                          used,
    output mea_pkg::lane_t                lane
);

    localparam int E = mea_pkg::EXP_BITS;

    logic signed [E-1:0] x;
    logic signed [E-1:0] y;
    logic signed [E:0]   wide;
    logic [E-1:0]        bits;
    logic                chk;

    assign x = used ? signed'(a_slot[E-1:0]) : '0;
    assign y = used ? signed'(b_slot[E-1:0]) : '0;

    always_comb
    begin
        wide = '0;
        chk  = 1'b0;
        case (cmd)
            mea_pkg::CMD_ADD:
            begin
                wide = (E+1)'(x) + (E+1)'(y);
                chk  = 1'b1;
            end
            mea_pkg::CMD_SUB:
            begin
                wide = (E+1)'(x) - (E+1)'(y);
                chk  = 1'b1;
            end
            mea_pkg::CMD_MIN: wide = (x < y) ? (E+1)'(x) : (E+1)'(y);
            mea_pkg::CMD_MAX: wide = (x > y) ? (E+1)'(x) : (E+1)'(y);
            mea_pkg::CMD_OR:  wide = (E+1)'(signed'(x | y));
            mea_pkg::CMD_NEG:
            begin
                wide = -((E+1)'(x));
                chk  = 1'b1;
            end
            default:          wide = '0;
        endcase
        bits = wide[E-1:0];
    end

    always_comb
    begin
        lane.slot = {{(mea_pkg::SLOT_BITS-E){bits[E-1]}}, bits};
        lane.ovf  = chk && (wide[E] != wide[E-1]);
        lane.ge   = (x >= y);
        lane.le   = (x <= y);
        lane.ne   = (x != y);
        lane.gt   = (x > y);
        lane.x    = x;
        lane.y    = y;
    end

endmodule

// File: design/mea_merge.sv
`timescale 1ns / 1ps

module mea_merge (
    input  mea_pkg::lane_t                lanes [mea_pkg::LANES],
    input  logic [mea_pkg::MODE_BITS-1:0] order_mode,
    output mea_pkg::result_t              res
);

    localparam int E = mea_pkg::EXP_BITS;
    localparam int D = mea_pkg::DEG_BITS;

    logic signed [D-1:0] da;
    logic signed [D-1:0] db;
    logic                decided;
    logic                first_gt;
    logic                lex_ge;
    logic                lex_gt;
    logic                ord;

    always_comb
    begin
        da       = '0;
        db       = '0;
        decided  = 1'b0;
        first_gt = 1'b0;
        res      = '0;
        res.a_ge_b        = 1'b1;
        res.a_le_b        = 1'b1;
        res.vectors_equal = 1'b1;
        for (int k = 0; k < mea_pkg::LANES; k++)
        begin
            da = da + signed'({{(D-E){lanes[k].x[E-1]}}, lanes[k].x});
            db = db + signed'({{(D-E){lanes[k].y[E-1]}}, lanes[k].y});
            res.result_exps[k*mea_pkg::SLOT_BITS +: mea_pkg::SLOT_BITS] = lanes[k].slot;
            res.overflow      = res.overflow | lanes[k].ovf;
            res.a_ge_b        = res.a_ge_b & lanes[k].ge;
            res.a_le_b        = res.a_le_b & lanes[k].le;
            res.vectors_equal = res.vectors_equal & ~lanes[k].ne;
        end
        for (int k = mea_pkg::LANES - 1; k >= 0; k--)
        begin
            if (lanes[k].ne)
            begin
                decided  = 1'b1;
                first_gt = lanes[k].gt;
            end
        end
        lex_ge = decided ? first_gt : 1'b1;
        lex_gt = decided & first_gt;
        case (order_mode)
            mea_pkg::ORD_DEG_LEX:    ord = (da != db) ? (da > db) : lex_ge;
            mea_pkg::ORD_DEG_INVLEX: ord = (da != db) ? (da > db) : ~lex_gt;
            default:                 ord = lex_ge;
        endcase
        res.order_greater = ord;
        res.degree_a      = da;
    end

endmodule

// File: design/monomial_exponent_alu.sv
`timescale 1ns / 1ps
// Monomial exponent ALU. Each input transaction on the s_ channel carries an
// operation and two exponent vectors of eight signed lanes; each produces one
// output transaction on the m_ channel with the lane-wise result, an overflow
// flag, divisibility and equality flags, the monomial-order flag and the total
// degree of the first vector.
// A transaction passes the per-lane units into the lane register, then the
// merging stage, which reduces the lane flags, sums the degrees and finds the
// first differing lane, into the output register. Throughput, set by the
// two pipeline registers, is one transaction per cycle while the receiver
// keeps m_tready high. When the receiver stalls, the output register holds
// its result and the lane register still takes one more transaction, so
// s_tready drops only when both stages are full. Reset empties the pipeline
// and sets order_mode to lex and var_count to eight. The configuration port
// (cfg_we, cfg_addr, cfg_wdata) writes register 0 (order_mode) or 1
// (var_count) and is meant to be used while no transaction is in flight.

module monomial_exponent_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [mea_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[2:0], a_exps[66:3], b_exps[130:67], zero fill
    input  logic [mea_pkg::IN_BITS-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_exps[63:0], overflow, a_ge_b, a_le_b, vectors_equal,
    // order_greater, degree_a[79:69]
    output logic [mea_pkg::OUT_BITS-1:0]  m_tdata
);

    localparam int SB = mea_pkg::SLOT_BITS;
    localparam int DB = mea_pkg::DATA_BITS;
    localparam int CB = mea_pkg::CMD_BITS;

    logic [mea_pkg::MODE_BITS-1:0] order_mode_reg;
    logic [mea_pkg::VC_BITS-1:0]   var_count_reg;
    logic [mea_pkg::VC_BITS-1:0]   used_cnt;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          adv1;
    logic                          adv2;
    mea_pkg::lane_t                lane_next [mea_pkg::LANES];
    mea_pkg::lane_t                lane_reg  [mea_pkg::LANES];
    mea_pkg::result_t              res_next;
    mea_pkg::result_t              res_reg;

    assign used_cnt = (var_count_reg > mea_pkg::VC_BITS'(mea_pkg::LANES))
                    ? mea_pkg::VC_BITS'(mea_pkg::LANES) : var_count_reg;

    assign adv2           = ~out_valid_reg | m_tready;
    assign adv1           = ~s1_valid_reg | adv2;
    assign s_tready       = adv1;
    assign s1_valid_next  = adv1 ? s_tvalid : s1_valid_reg;
    assign out_valid_next = adv2 ? s1_valid_reg : out_valid_reg;

    for (genvar k = 0; k < mea_pkg::LANES; k++)
    begin : g_lane
        mea_lane u_lane (
            .cmd    (s_tdata[CB-1:0]),
            .a_slot (s_tdata[CB + k*SB +: SB]),
            .b_slot (s_tdata[CB + DB + k*SB +: SB]),
            .used   (mea_pkg::VC_BITS'(k) < used_cnt),
            .lane   (lane_next[k])
        );
    end

    mea_merge u_merge (
        .lanes      (lane_reg),
        .order_mode (order_mode_reg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= mea_pkg::ORD_LEX;
            var_count_reg  <= mea_pkg::VC_BITS'(mea_pkg::LANES);
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr == mea_pkg::CFG_ORDER_MODE)
            begin
                order_mode_reg <= cfg_wdata[mea_pkg::MODE_BITS-1:0];
            end
            if (cfg_we && cfg_addr == mea_pkg::CFG_VAR_COUNT)
            begin
                var_count_reg <= cfg_wdata[mea_pkg::VC_BITS-1:0];
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            lane_reg <= lane_next;
        end
        if (adv2)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mea_pkg::OUT_BITS'(res_reg);

endmodule
